// ----- rtl/apt_pkg.sv -----
// ----------------------------------------------------------------------------
// apt_pkg: shared types and constants for the affine point transform
// Fixed-point widths, the configuration register map with its reset values,
// and the control bundle that steps the row datapaths.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int COMP_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * COMP_W;
  localparam int TERM_W    = COMP_W + FRAC_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_ROWS  = 3;
  localparam int NUM_CFG   = 2 * NUM_ROWS;
  localparam int CFG_W     = 2 * COMP_W;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COMP_W-1:0] comp_t;

  localparam comp_t SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam comp_t SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5
  } cfg_reg_t;

  // Identity matrix with zero translation.
  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  // Coefficients of one matrix row, unpacked from its two registers.
  typedef struct packed {
    comp_t c0;
    comp_t c1;
    comp_t c2;
    comp_t t;
  } row_coef_t;

  // Load enables for the three datapath register stages.
  typedef struct packed {
    logic en_mul;
    logic en_sum;
    logic en_out;
  } stage_en_t;

endpackage

// ----- rtl/apt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// apt_cfg_regs: matrix coefficient register file
// Holds the six 64-bit configuration registers and presents them as
// per-row coefficient sets. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module apt_cfg_regs (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       wr_en,
  input  logic [apt_pkg::CFG_IDX_W-1:0]              wr_index,
  input  logic [apt_pkg::CFG_W-1:0]                  wr_data,
  output apt_pkg::row_coef_t [apt_pkg::NUM_ROWS-1:0] rows
);
  import apt_pkg::*;

  logic [CFG_W-1:0] regs [NUM_CFG];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        regs[i] <= CFG_RESET[i];
      end
    end else if (wr_en && (wr_index <= REG_ROW2_COLS23)) begin
      regs[wr_index] <= wr_data;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      rows[r].c0 = regs[2*r][COMP_W-1:0];
      rows[r].c1 = regs[2*r][CFG_W-1:COMP_W];
      rows[r].c2 = regs[2*r+1][COMP_W-1:0];
      rows[r].t  = regs[2*r+1][CFG_W-1:COMP_W];
    end
  end

endmodule

// ----- rtl/apt_row.sv -----
// ----------------------------------------------------------------------------
// apt_row: one output component of the transform
// Three registered steps: products, exact sum with rounding offset, then
// shift to Q16.16 with saturation to 32 bits.
// ----------------------------------------------------------------------------
module apt_row (
  input  logic               clk,
  input  apt_pkg::stage_en_t en,
  input  apt_pkg::row_coef_t coef,
  input  logic               mode,
  input  apt_pkg::comp_t     x,
  input  apt_pkg::comp_t     y,
  input  apt_pkg::comp_t     z,
  output apt_pkg::comp_t     res,
  output logic               sat
);
  import apt_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
  localparam int HI_W = SUM_W - FRAC_W - COMP_W + 1;

  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  logic signed [TERM_W-1:0] trans;
  logic signed [SUM_W-1:0]  sum;
  logic [HI_W-1:0]          hi_bits;
  logic                     ovf;

  always_ff @(posedge clk) begin
    if (en.en_mul) begin
      prod_x <= PROD_W'(x) * PROD_W'(coef.c0);
      prod_y <= PROD_W'(y) * PROD_W'(coef.c1);
      prod_z <= PROD_W'(z) * PROD_W'(coef.c2);
      trans  <= mode ? '0 : {coef.t, {FRAC_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_sum) begin
      sum <= SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z) + SUM_W'(trans)
             + ROUND_HALF;
    end
  end

  // The quotient fits in 32 bits when all bits from the sign down to
  // bit 31 of the shifted sum agree.
  assign hi_bits = sum[SUM_W-1:FRAC_W+COMP_W-1];
  assign ovf     = !((&hi_bits) || !(|hi_bits));

  always_ff @(posedge clk) begin
    if (en.en_out) begin
      sat <= ovf;
      if (ovf) begin
        res <= hi_bits[HI_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        res <= sum[FRAC_W+COMP_W-1:FRAC_W];
      end
    end
  end

endmodule

// ----- rtl/affine_point_transform.sv -----
// ----------------------------------------------------------------------------
// affine_point_transform: Q16.16 affine transform of 3D points and vectors
// Datapath: each transaction passes through the input, product, sum and
// result registers, in that order, after the input edge that accepts it.
// Throughput: one transaction per cycle, sustained while out_ready is high;
// each stage has its own valid bit, so bubbles close up under backpressure.
// Reset: synchronous, clears all stage valid bits and loads the identity
// matrix with zero translation into the coefficient registers.
// ----------------------------------------------------------------------------
module affine_point_transform (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [apt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apt_pkg::CFG_W-1:0]     cfg_data,
  // Input vector channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_y,
  input  logic signed [31:0]            in_z,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_x,
  output logic signed [31:0]            out_y,
  output logic signed [31:0]            out_z,
  output logic                          saturated
);
  import apt_pkg::*;

  // The coefficient file always takes a write. The user must write only while the
  // pipeline is empty, unchecked by the block, so the datapath can read the registers directly.
  assign cfg_ready = 1'b1;

  row_coef_t [NUM_ROWS-1:0] rows;

  apt_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .rows     (rows)
  );

  // Stage valid bits: input register, products, sum, result.
  logic v_in;
  logic v_mul;
  logic v_sum;
  logic v_out;

  // A stage can load when it is empty or its contents move on this cycle.
  logic rdy_in;
  logic rdy_mul;
  logic rdy_sum;
  logic rdy_out;

  assign rdy_out = !v_out || out_ready;
  assign rdy_sum = !v_sum || rdy_out;
  assign rdy_mul = !v_mul || rdy_sum;
  assign rdy_in  = !v_in  || rdy_mul;

  assign in_ready = rdy_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in  <= 1'b0;
      v_mul <= 1'b0;
      v_sum <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (rdy_in)  v_in  <= in_valid;
      if (rdy_mul) v_mul <= v_in;
      if (rdy_sum) v_sum <= v_mul;
      if (rdy_out) v_out <= v_sum;
    end
  end

  // Input register; the payload is captured on every accepted transaction.
  comp_t x_q;
  comp_t y_q;
  comp_t z_q;
  logic  mode_q;

  always_ff @(posedge clk) begin
    if (rdy_in) begin
      x_q    <= in_x;
      y_q    <= in_y;
      z_q    <= in_z;
      mode_q <= mode;
    end
  end

  stage_en_t en;
  assign en.en_mul = rdy_mul;
  assign en.en_sum = rdy_sum;
  assign en.en_out = rdy_out;

  comp_t              res  [NUM_ROWS];
  logic [NUM_ROWS-1:0] sat;

  // One datapath per matrix row; all three share the stage enables.
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    apt_row u_row (
      .clk  (clk),
      .en   (en),
      .coef (rows[r]),
      .mode (mode_q),
      .x    (x_q),
      .y    (y_q),
      .z    (z_q),
      .res  (res[r]),
      .sat  (sat[r])
    );
  end

  assign out_valid = v_out;
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  // The flag covers all three components of the same transaction.
  assign saturated = |sat;

endmodule

// ----- rtl/apt_checker.sv -----
// ----------------------------------------------------------------------------
// apt_checker: port-level checks for the affine point transform
// Watches the top-level ports for output hold, reset and flow behavior.
// ----------------------------------------------------------------------------
module apt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [31:0]            out_x,
  input logic signed [31:0]            out_y,
  input logic signed [31:0]            out_z,
  input logic                          saturated
);
  import apt_pkg::*;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(saturated))
    else $error("stalled result changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // With nothing waiting at the output, the pipeline cannot be blocked.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // The saturation flag implies at least one clipped component.
  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      out_x == SAT_MAX || out_x == SAT_MIN || out_y == SAT_MAX ||
      out_y == SAT_MIN || out_z == SAT_MAX || out_z == SAT_MIN)
    else $error("saturated set with no clipped component");

  // The coefficient file never refuses a write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind affine_point_transform apt_checker u_apt_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .saturated (saturated)
);
